[rtl/vbs_pkg.sv]
`timescale 1ns / 1ps
package vbs_pkg;
  localparam int MAX_JOINTS_DEF = 64;
  localparam int WORDS = 12;
  localparam int IN_W = 1 + 6 + 4 + 32 * 9;
  localparam int IN_BYTES = (IN_W + 7) / 8;
  localparam int OUT_W = 32 * 6 + 1;
  localparam int OUT_BYTES = (OUT_W + 7) / 8;
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_SKIN = 1'b1;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [47:0] rnd16(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd32768;
    return t[63:16];
  endfunction
endpackage

[rtl/vbs_mul.sv]
`timescale 1ns / 1ps
module vbs_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] p
);
  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end
endmodule

[rtl/vbs_div255.sv]
`timescale 1ns / 1ps
module vbs_div255 (
  input  logic               clk,
  input  logic signed [41:0] acc,
  output logic signed [31:0] q
);
  import vbs_pkg::*;
  logic [41:0] mag;
  logic [41:0] y;
  logic [41:0] y_r;
  logic        neg_r;
  logic        neg_q;
  logic [41:0] sh;
  logic [10:0] dsum;
  logic [41:0] sh_r;
  logic [10:0] dsum_r;
  logic [8:0]  fold;
  logic [41:0] quo;

  // y/255 = sum of y >> 8k plus the base-256 digit sum folded once more
  always_comb begin
    mag = acc[41] ? 42'(-acc) : 42'(acc);
    y = mag + 42'd127;
  end

  always_comb begin
    sh = (y_r >> 8) + (y_r >> 16) + (y_r >> 24) + (y_r >> 32) + (y_r >> 40);
    dsum = 11'(y_r[7:0]) + 11'(y_r[15:8]) + 11'(y_r[23:16]) + 11'(y_r[31:24])
         + 11'(y_r[39:32]) + 11'(y_r[41:40]);
  end

  always_ff @(posedge clk) begin
    y_r <= y;
    neg_r <= acc[41];
    sh_r <= sh;
    dsum_r <= dsum;
    neg_q <= neg_r;
  end

  always_comb begin
    fold = 9'(dsum_r[7:0]) + 9'(dsum_r[10:8]);
    quo = sh_r + 42'(dsum_r[10:8]) + ((fold >= 9'd255) ? 42'd1 : 42'd0);
    q = sat32(neg_q ? -64'(quo) : 64'(quo));
  end
endmodule

[rtl/vertex_blend_skinning.sv]
`timescale 1ns / 1ps
// A vertex transaction blends J joints (J = blends used, 1..4), then runs /255, adjoint and
// transform before m_axis_tvalid; a matrix word write completes in its accepting cycle.
// One transaction in flight, ready again the cycle after the result transaction;
// one shared 32x32 multiplier serves blend, adjoint and transform; /255 has its own divider.
// Reset: rst is synchronous and clears control state; the joint matrix store
// holds undefined values until written.
module vertex_blend_skinning #(
  parameter int MAX_JOINTS = vbs_pkg::MAX_JOINTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // func, joint_slot, word_slot, matrix_word, pos_x..z, nrm_x..z, blend_joints, blend_weights
  input  logic [vbs_pkg::IN_BYTES*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // out_x, out_y, out_z, out_nx, out_ny, out_nz, bad_joint
  output logic [vbs_pkg::OUT_BYTES*8-1:0] m_axis_tdata
);
  import vbs_pkg::*;
  localparam int DEPTH = MAX_JOINTS * WORDS;
  localparam int AW = $clog2(DEPTH);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_BLEND = 6'b000010, S_DIV = 6'b000100,
    S_ADJ = 6'b001000, S_XF = 6'b010000, S_OUT = 6'b100000
  } state_t;
  state_t state;

  logic [31:0] mem [DEPTH];
  logic [31:0] rd;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic wr_en;

  logic signed [31:0] pv [3];
  logic signed [31:0] nv [3];
  logic [31:0] bj, bw;
  logic signed [41:0] acc [WORDS];
  logic signed [31:0] m [WORDS];
  logic signed [31:0] n [9];
  logic signed [63:0] sum;
  logic signed [31:0] res [6];
  logic bad;
  logic [1:0] jn;
  logic [4:0] cnt;
  logic [1:0] col, col_d;
  logic [2:0] row, row_d;
  logic [1:0] nr;

  logic signed [31:0] ma, mb;
  logic signed [63:0] mp;
  vbs_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));
  logic signed [41:0] dacc;
  logic signed [31:0] dq;
  vbs_div255 u_div (.clk(clk), .acc(dacc), .q(dq));

  logic [7:0] cur_idx, cur_w;
  logic jok;
  assign cur_idx = bj[{jn, 3'b000} +: 8];
  assign cur_w = bw[{jn, 3'b000} +: 8];
  assign jok = 32'(cur_idx) < 32'(MAX_JOINTS);

  // adjoint operands, four per entry: a*b - c*d
  function automatic logic [3:0] adj_op(input logic [5:0] i);
    logic [3:0] t [36];
    t = '{4'd5,4'd10,4'd6,4'd9, 4'd6,4'd8,4'd4,4'd10, 4'd4,4'd9,4'd5,4'd8,
          4'd2,4'd9,4'd1,4'd10, 4'd0,4'd10,4'd2,4'd8, 4'd1,4'd8,4'd0,4'd9,
          4'd1,4'd6,4'd2,4'd5, 4'd2,4'd4,4'd0,4'd6, 4'd0,4'd5,4'd1,4'd4};
    return t[i];
  endfunction

  always_comb begin
    ma = '0;
    mb = '0;
    nr = 2'(row - 3'd3);
    if (state == S_BLEND) begin
      ma = {24'd0, cur_w};
      mb = rd;
    end else if (state == S_ADJ && cnt < 5'd18) begin
      ma = m[adj_op({cnt, 1'b0})];
      mb = m[adj_op({cnt, 1'b1})];
    end else if (state == S_XF && cnt < 5'd18) begin
      if (row < 3'd3) begin
        ma = m[{row[1:0], col}];
        mb = pv[col];
      end else begin
        ma = n[{1'b0, nr, 1'b0} + 4'(nr) + 4'(col)];
        mb = nv[col];
      end
    end
  end

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign dacc = (state == S_DIV && cnt < 5'd12) ? acc[cnt[3:0]] : '0;

  logic [5:0] w_js;
  logic [3:0] w_ws;
  assign w_js = s_axis_tdata[6:1];
  assign w_ws = s_axis_tdata[10:7];
  assign wr_en = in_acc && s_axis_tdata[0] == FUNC_WRITE && w_ws < 4'(WORDS)
                 && 32'(w_js) < 32'(MAX_JOINTS);
  assign wr_addr = AW'(32'(w_js) * WORDS + 32'(w_ws));

  always_ff @(posedge clk) begin
    if (wr_en)
      mem[wr_addr] <= s_axis_tdata[42:11];
    rd <= mem[rd_addr];
  end

  // blend read pipeline: cnt issues the address, rd registers the data, then mp registers the product
  assign rd_addr = AW'(32'(cur_idx) * WORDS + 32'(cnt[3:0]));

  logic signed [63:0] pn;
  assign pn = 64'(rnd16(mp));

  always_ff @(posedge clk) begin
    col_d <= col;
    row_d <= row;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc && s_axis_tdata[0] == FUNC_SKIN) begin
            for (int i = 0; i < 3; i++) begin
              pv[i] <= s_axis_tdata[43 + 32*i +: 32];
              nv[i] <= s_axis_tdata[139 + 32*i +: 32];
            end
            bj <= s_axis_tdata[266:235];
            bw <= s_axis_tdata[298:267];
            for (int k = 0; k < WORDS; k++) acc[k] <= '0;
            bad <= 1'b0;
            jn <= '0;
            cnt <= '0;
            state <= S_BLEND;
          end
        end
        S_BLEND: begin
          if (cnt >= 5'd2 && jok)
            acc[4'(cnt - 5'd2)] <= acc[4'(cnt - 5'd2)] + 42'(mp);
          if (cnt == 5'd13) begin
            if (!jok) bad <= 1'b1;
            cnt <= '0;
            if (jn == 2'd3 || bw[{jn + 2'd1, 3'b000} +: 8] == 8'd0) begin
              state <= S_DIV;
            end else begin
              jn <= jn + 2'd1;
            end
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_DIV: begin
          if (cnt >= 5'd2) m[4'(cnt - 5'd2)] <= dq;
          if (cnt == 5'd13) begin
            cnt <= '0;
            state <= S_ADJ;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_ADJ: begin
          if (cnt >= 5'd1) begin
            if (cnt[0]) sum <= pn;
            else n[4'((cnt >> 1) - 5'd1)] <= sat32(sum - pn);
          end
          if (cnt == 5'd18) begin
            cnt <= '0;
            col <= '0;
            row <= '0;
            state <= S_XF;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_XF: begin
          if (cnt >= 5'd1) begin
            case (col_d)
              2'd0: sum <= pn + ((row_d < 3'd3) ? 64'(m[{row_d[1:0], 2'd3}]) : 64'sd0);
              2'd1: sum <= sum + pn;
              default: res[row_d] <= sat32(sum + pn);
            endcase
          end
          if (col == 2'd2) begin
            col <= '0;
            row <= row + 3'd1;
          end else begin
            col <= col + 2'd1;
          end
          if (cnt == 5'd18) begin
            cnt <= '0;
            state <= S_OUT;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_OUT: if (m_axis_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    for (int i = 0; i < 6; i++) m_axis_tdata[32*i +: 32] = res[i];
    m_axis_tdata[192] = bad;
  end

`ifndef SYNTHESIS
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
  a_stable: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while waiting");
  a_oh: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
`endif
endmodule
